@@ rtl/adc_moving_average_and_delta_macros.svh @@
// assertion shorthands used by the checker file
`ifndef ADC_MOVING_AVERAGE_AND_DELTA_MACROS_SVH
`define ADC_MOVING_AVERAGE_AND_DELTA_MACROS_SVH

// clocked property, switched off while reset is low
`define ADCMAD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked property that also holds while reset is low
`define ADCMAD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/adcmad_pkg.sv @@
`default_nettype none

package adcmad_pkg;

    // payload widths
    localparam int CHANNEL_W = 2;
    localparam int SAMPLE_W  = 12;
    localparam int AVG_W     = 16;
    localparam int CHANGE_W  = 14;
    localparam int REF_W     = 13;

    // defaults for the top level parameters
    localparam int WINDOW_LENGTH_DEF = 16;
    localparam int CHANNEL_COUNT_DEF = 3;

    localparam int FULL_SCALE = 4095;

    // register map
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_REFERENCE_ADDR = 2'd0;
    localparam logic [REF_W-1:0]      REF_RESET          = 13'd3300;

    // change scaling: |diff| * ref, then divided by full scale through a reciprocal
    localparam int CHG_N_W     = SAMPLE_W + REF_W;
    localparam int CHG_SHIFT   = CHG_N_W + SAMPLE_W;
    localparam int CHG_MUL_W   = CHG_N_W + 1;
    localparam int CHG_PROD_W  = CHG_N_W + CHG_MUL_W;
    localparam logic [CHG_MUL_W-1:0] CHG_MUL = CHG_MUL_W'(
        ((64'd1 << CHG_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

endpackage

`default_nettype wire

@@ rtl/adcmad_ram.sv @@
`default_nettype none

module adcmad_ram
    import adcmad_pkg::*;
#(
    parameter int WIDTH = SAMPLE_W,
    parameter int DEPTH = CHANNEL_COUNT_DEF * WINDOW_LENGTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/adcmad_apb.sv @@
`default_nettype none

module adcmad_apb
    import adcmad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [REF_W-1:0]      reference_mv
);

    logic [REF_W-1:0] ref_reg;
    logic             wr_en;

    assign wr_en = psel && penable && pwrite && (paddr == REG_REFERENCE_ADDR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= REF_RESET;
        end else if (wr_en) begin
            ref_reg <= pwdata[REF_W-1:0];
        end
    end

    assign pready       = 1'b1;
    assign prdata       = (paddr == REG_REFERENCE_ADDR) ? APB_DATA_W'(ref_reg) : '0;
    assign reference_mv = ref_reg;

endmodule

`default_nettype wire

@@ rtl/adc_moving_average_and_delta.sv @@
// registers: an input transfer goes through stage 1, stage 2 and the output register to m_*
// throughput: one sample per cycle unless m_ready stalls; one ring read and write-back per sample
// reset: synchronous, active low; clears the pipeline, per-channel sums, previous samples,
// write positions and wrap flags, and sets the reference to 3300 mV; the ring memory itself
// is not cleared, unwritten entries read as zero via the per-channel wrap flag
`default_nettype none

module adc_moving_average_and_delta
    import adcmad_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    // sample input
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CHANNEL_W-1:0]       s_channel,
    input  logic [SAMPLE_W-1:0]        s_sample,
    // results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [AVG_W-1:0]           m_average_q4,
    output logic signed [CHANGE_W-1:0] m_change_millivolts
);

    localparam int CH_W     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int POS_W    = $clog2(WINDOW_LENGTH);
    localparam int DEPTH    = CHANNEL_COUNT * WINDOW_LENGTH;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SUM_W    = $clog2(WINDOW_LENGTH * FULL_SCALE + 1);

    // average = floor(sum * 16 / window) via an exact reciprocal multiply
    localparam int AVG_N_W    = SUM_W + 4;
    localparam int AVG_SHIFT  = AVG_N_W + POS_W;
    localparam int AVG_MUL_W  = AVG_N_W + 1;
    localparam int AVG_PROD_W = AVG_N_W + AVG_MUL_W;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(
        ((64'd1 << AVG_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LENGTH - 1);

    // ---------------------------------------------------------------- configuration
    logic [REF_W-1:0] reference_mv;

    adcmad_apb u_apb (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .reference_mv (reference_mv)
    );

    // ---------------------------------------------------------------- pipeline control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic m_valid_reg;
    logic in_xfer;
    logic s1_move;
    logic s2_move;

    // each stage moves on when the one after it is empty or moving too
    assign s2_move = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s1_move = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign s_ready = !s1_valid_reg || s1_move;
    assign in_xfer = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // ---------------------------------------------------------------- per-channel state
    // write position and wrap flag move at the transfer, so a following sample of the
    // same channel already reads the next ring slot; sum and previous sample move when
    // the sample leaves stage 1, in order
    logic [POS_W-1:0]    pos_reg  [CHANNEL_COUNT];
    logic                wrap_reg [CHANNEL_COUNT];
    logic [SUM_W-1:0]    sum_reg  [CHANNEL_COUNT];
    logic [SAMPLE_W-1:0] prev_reg [CHANNEL_COUNT];

    logic             ch_ok;
    logic [CH_W-1:0]  ch_idx;
    logic [POS_W-1:0] pos_cur;
    logic [POS_W-1:0] pos_next;
    logic [ADDR_W-1:0] rd_addr;
    logic             rd_en;

    assign ch_ok    = 32'(s_channel) < 32'(CHANNEL_COUNT);
    assign ch_idx   = CH_W'(s_channel);
    assign pos_cur  = ch_ok ? pos_reg[ch_idx] : '0;
    assign pos_next = (pos_cur == POS_LAST) ? '0 : pos_cur + POS_W'(1);
    assign rd_addr  = ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(WINDOW_LENGTH)) + ADDR_W'(pos_cur);
    assign rd_en    = in_xfer && ch_ok;

    // ---------------------------------------------------------------- stage 1: ring read
    logic                s1_ok_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_hit_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [SAMPLE_W-1:0] ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_ok_reg     <= ch_ok;
            s1_ch_reg     <= ch_idx;
            s1_sample_reg <= s_sample;
            s1_hit_reg    <= ch_ok && wrap_reg[ch_idx];
            s1_addr_reg   <= rd_addr;
        end
    end

    // write-back of the new sample over the oldest one
    logic ram_we;

    assign ram_we = s1_move && s1_ok_reg;

    adcmad_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (s1_sample_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // a slot not yet written since reset counts as zero
    logic [SAMPLE_W-1:0] oldest;
    logic [SUM_W-1:0]    sum_old;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] prev_old;
    logic                chg_neg;
    logic [SAMPLE_W-1:0] diff_mag;

    // an out-of-range channel compares the sample with itself, so its difference is zero
    assign oldest   = s1_hit_reg ? ram_rdata : '0;
    assign sum_old  = s1_ok_reg ? sum_reg[s1_ch_reg] : '0;
    assign prev_old = s1_ok_reg ? prev_reg[s1_ch_reg] : s1_sample_reg;
    assign sum_next = sum_old - SUM_W'(oldest) + SUM_W'(s1_sample_reg);
    assign chg_neg  = s1_sample_reg < prev_old;
    assign diff_mag = chg_neg ? prev_old - s1_sample_reg : s1_sample_reg - prev_old;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                pos_reg[c]  <= '0;
                wrap_reg[c] <= 1'b0;
                sum_reg[c]  <= '0;
                prev_reg[c] <= '0;
            end
        end else begin
            if (rd_en) begin
                pos_reg[ch_idx] <= pos_next;
                if (pos_cur == POS_LAST) begin
                    wrap_reg[ch_idx] <= 1'b1;
                end
            end
            if (ram_we) begin
                sum_reg[s1_ch_reg]  <= sum_next;
                prev_reg[s1_ch_reg] <= s1_sample_reg;
            end
        end
    end

    // ---------------------------------------------------------------- stage 2: products
    logic [AVG_PROD_W-1:0] avg_prod_reg;
    logic [CHG_N_W-1:0]    chg_n_reg;
    logic                  chg_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_move) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_move) begin
            s2_valid_reg <= 1'b0;
        end
    end

    // an out-of-range channel gives zero sum and zero difference, hence a zero result
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            avg_prod_reg <= AVG_PROD_W'({sum_old, 4'b0000}) * AVG_PROD_W'(AVG_MUL);
            chg_n_reg    <= CHG_N_W'(diff_mag) * CHG_N_W'(reference_mv);
            chg_neg_reg  <= chg_neg;
        end
    end

    // ---------------------------------------------------------------- output register
    logic [CHG_PROD_W-1:0] chg_prod;
    logic [CHANGE_W-1:0]   chg_mag;

    // divide by full scale, truncating the magnitude, then reapply the sign
    assign chg_prod = CHG_PROD_W'(chg_n_reg) * CHG_PROD_W'(CHG_MUL);
    assign chg_mag  = CHANGE_W'(chg_prod[CHG_SHIFT +: CHANGE_W-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_move) begin
            m_average_q4        <= avg_prod_reg[AVG_SHIFT +: AVG_W];
            m_change_millivolts <= chg_neg_reg ? -chg_mag : chg_mag;
        end
    end

endmodule

`default_nettype wire

@@ rtl/adcmad_checker.sv @@
`default_nettype none
`include "adc_moving_average_and_delta_macros.svh"

module adcmad_checker
    import adcmad_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [APB_ADDR_W-1:0]      paddr,
    input logic [APB_DATA_W-1:0]      pwdata,
    input logic [APB_DATA_W-1:0]      prdata,
    input logic                       pready,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [AVG_W-1:0]           m_average_q4,
    input logic signed [CHANGE_W-1:0] m_change_millivolts
);

    // no result survives reset
    `ADCMAD_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    // a stalled result holds
    `ADCMAD_ASSERT(a_stall_hold,
        m_valid && !m_ready |=>
            m_valid && $stable(m_average_q4) && $stable(m_change_millivolts),
        "stalled result changed")

    // with the output register empty the whole pipe drains, so input is taken
    `ADCMAD_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "input stalled with empty output")

    // a reference write reads back on the next cycle
    `ADCMAD_ASSERT(a_ref_readback,
        psel && penable && pwrite && pready && paddr == REG_REFERENCE_ADDR |=>
            paddr != REG_REFERENCE_ADDR || prdata[REF_W-1:0] == $past(pwdata[REF_W-1:0]),
        "reference readback mismatch")

endmodule

bind adc_moving_average_and_delta adcmad_checker u_checker (.*);

`default_nettype wire
